/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/lia_pkg.sv */
// ----------------------------------------------------------------------------
// lia_pkg
// Types, constants and helper functions of the three-channel lock-in block.
// ----------------------------------------------------------------------------
package lia_pkg;

    localparam int SAMPLES    = 8192;
    localparam int ADDR_W     = 13;
    localparam int IDX_W      = 14;
    localparam int SMP_W      = 16;
    localparam int LVL_W      = 16;
    localparam int CFG_W      = 16;
    localparam int DEPTH_W    = 10;
    localparam int PS_W       = 27;
    localparam int EC_W       = 13;
    localparam int Q_W        = 11;
    localparam int DVD_W      = 48;
    localparam int CNT_W      = 6;
    localparam int ACC_W      = 48;
    localparam int RES_W      = 32;
    localparam int SHIFT_N    = 13;
    localparam int CORD_STEPS = 24;
    localparam int STEP_W     = 5;
    localparam int CORD_W     = 34;
    localparam int ATAN_W     = 30;
    localparam int RND_W      = 35;
    localparam logic [CFG_W-1:0] LOW_RST  = 16'd6554;
    localparam logic [CFG_W-1:0] HIGH_RST = 16'd58982;
    localparam logic [CFG_W-1:0] GAIN_RST = 16'd1;
    localparam logic signed [CORD_W-1:0] CORD_X0 = 34'sd652032874;

    typedef enum logic [1:0] {
        CFG_LOW  = 2'd0,
        CFG_HIGH = 2'd1,
        CFG_GAIN = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DSEL_OFF = 2'd0,
        DSEL_PH  = 2'd1,
        DSEL_ST  = 2'd2,
        DSEL_OUT = 2'd3
    } dsel_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_DIV_OFF,
        ST_PH_GO,
        ST_DIV_PH,
        ST_ST_GO,
        ST_DIV_ST,
        ST_RD,
        ST_COR,
        ST_MAC,
        ST_ADV,
        ST_OUT_GO,
        ST_DIV_OUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  clr;
        logic  prep;
        logic  div_start;
        dsel_t dsel;
        logic  div_take;
        logic  rd;
        logic  cor_start;
        logic  mac;
        logic  adv;
        logic  out_next;
    } cmd_t;

    typedef struct packed {
        logic closing;
        logic no_edge;
        logic div_done;
        logic cor_done;
        logic mac_last;
        logic samp_last;
        logic out_last;
    } sts_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_of(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 30'd536870912;
                5'd1:    v = 30'd316933406;
                5'd2:    v = 30'd167458907;
                5'd3:    v = 30'd85004756;
                5'd4:    v = 30'd42667331;
                5'd5:    v = 30'd21354465;
                5'd6:    v = 30'd10679838;
                5'd7:    v = 30'd5340245;
                5'd8:    v = 30'd2670163;
                5'd9:    v = 30'd1335087;
                5'd10:   v = 30'd667544;
                5'd11:   v = 30'd333772;
                5'd12:   v = 30'd166886;
                5'd13:   v = 30'd83443;
                5'd14:   v = 30'd41722;
                5'd15:   v = 30'd20861;
                5'd16:   v = 30'd10430;
                5'd17:   v = 30'd5215;
                5'd18:   v = 30'd2608;
                5'd19:   v = 30'd1304;
                5'd20:   v = 30'd652;
                5'd21:   v = 30'd326;
                5'd22:   v = 30'd163;
                5'd23:   v = 30'd81;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    // round Q5.30 to Q1.15 half up, clamp to the symmetric range
    function automatic logic signed [SMP_W-1:0] to_q15(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] t;
        logic signed [SMP_W-1:0] r;
        begin
            t = (v + 35'sd16384) >>> 15;
            if (t > 35'sd32767)
                r = 16'sd32767;
            else if (t < -35'sd32767)
                r = -16'sd32767;
            else
                r = t[SMP_W-1:0];
            return r;
        end
    endfunction

endpackage

/* hw/rtl/lia_div.sv */
// ----------------------------------------------------------------------------
// lia_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lia_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lia_pkg::DVD_W-1:0]     dividend,
    input  logic [lia_pkg::PS_W-1:0]      divisor,
    output logic [lia_pkg::DVD_W-1:0]     quot,
    output logic [lia_pkg::PS_W-1:0]      rem,
    output logic                          done
);
    logic                          run_reg;
    logic                          done_reg;
    logic [lia_pkg::CNT_W-1:0]     cnt_reg;
    logic [lia_pkg::DVD_W-1:0]     dvd_reg;
    logic [lia_pkg::PS_W-1:0]      rem_reg;
    logic [lia_pkg::PS_W-1:0]      dvs_reg;
    logic [lia_pkg::PS_W:0]        sh;
    logic [lia_pkg::PS_W:0]        diff;
    logic                          ge;

    always_comb
    begin
        sh   = {rem_reg, dvd_reg[lia_pkg::DVD_W-1]};
        diff = sh - {1'b0, dvs_reg};
        ge   = (sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lia_pkg::CNT_W'(lia_pkg::DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[lia_pkg::DVD_W-2:0], ge};
            rem_reg <= ge ? diff[lia_pkg::PS_W-1:0] : sh[lia_pkg::PS_W-1:0];
        end
    end

    assign quot = dvd_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/lia_cordic.sv */
// ----------------------------------------------------------------------------
// lia_cordic
// Iterative rotation CORDIC: table step to Q1.15 sine and cosine.
// ----------------------------------------------------------------------------
module lia_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lia_pkg::DEPTH_W-1:0]       k,
    output logic signed [lia_pkg::SMP_W-1:0]  sn,
    output logic signed [lia_pkg::SMP_W-1:0]  cs,
    output logic                              done
);
    logic                               run_reg;
    logic                               fin_reg;
    logic                               done_reg;
    logic                               flip_reg;
    logic [lia_pkg::STEP_W-1:0]         i_reg;
    logic signed [lia_pkg::CORD_W-1:0]  x_reg;
    logic signed [lia_pkg::CORD_W-1:0]  y_reg;
    logic signed [lia_pkg::CORD_W-1:0]  z_reg;
    logic signed [lia_pkg::SMP_W-1:0]   sn_reg;
    logic signed [lia_pkg::SMP_W-1:0]   cs_reg;
    logic signed [lia_pkg::CORD_W-1:0]  dx;
    logic signed [lia_pkg::CORD_W-1:0]  dy;
    logic signed [lia_pkg::CORD_W-1:0]  at;
    logic                               flip;
    logic [lia_pkg::DEPTH_W-1:0]        kk;
    logic signed [lia_pkg::CORD_W-1:0]  z0;
    logic signed [lia_pkg::RND_W-1:0]   xv;
    logic signed [lia_pkg::RND_W-1:0]   yv;

    always_comb
    begin
        dx   = y_reg >>> i_reg;
        dy   = x_reg >>> i_reg;
        at   = lia_pkg::CORD_W'(lia_pkg::atan_of(i_reg));
        // left half plane: turn by half a turn, negate at the end
        flip = k[lia_pkg::DEPTH_W-1] ^ k[lia_pkg::DEPTH_W-2];
        kk   = {k[lia_pkg::DEPTH_W-1] ^ flip, k[lia_pkg::DEPTH_W-2:0]};
        z0   = {{(lia_pkg::CORD_W - 32){kk[lia_pkg::DEPTH_W-1]}}, kk,
                {(32 - lia_pkg::DEPTH_W){1'b0}}};
        xv   = flip_reg ? -lia_pkg::RND_W'(x_reg) : lia_pkg::RND_W'(x_reg);
        yv   = flip_reg ? -lia_pkg::RND_W'(y_reg) : lia_pkg::RND_W'(y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= '0;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == lia_pkg::STEP_W'(lia_pkg::CORD_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= lia_pkg::CORD_X0;
            y_reg    <= '0;
            z_reg    <= z0;
            flip_reg <= flip;
        end
        else if (run_reg)
        begin
            if (!z_reg[lia_pkg::CORD_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        if (fin_reg)
        begin
            sn_reg <= lia_pkg::to_q15(yv);
            cs_reg <= lia_pkg::to_q15(xv);
        end
    end

    assign sn   = sn_reg;
    assign cs   = cs_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/lia_dp.sv */
// ----------------------------------------------------------------------------
// lia_dp
// Datapath: sample store, edge tracking, phase stepping, MAC and scaling.
// ----------------------------------------------------------------------------
module lia_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [lia_pkg::CFG_W-1:0]         cfg_data,
    input  logic [lia_pkg::LVL_W-1:0]         ref_level,
    input  logic signed [lia_pkg::SMP_W-1:0]  chan_a,
    input  logic signed [lia_pkg::SMP_W-1:0]  chan_b,
    input  logic signed [lia_pkg::SMP_W-1:0]  chan_c,
    input  logic                              frame_end,
    input  lia_pkg::cmd_t                     cmd,
    output lia_pkg::sts_t                     sts,
    output logic signed [lia_pkg::RES_W-1:0]  a_in_phase,
    output logic signed [lia_pkg::RES_W-1:0]  a_quadrature,
    output logic signed [lia_pkg::RES_W-1:0]  b_in_phase,
    output logic signed [lia_pkg::RES_W-1:0]  b_quadrature,
    output logic signed [lia_pkg::RES_W-1:0]  c_in_phase,
    output logic signed [lia_pkg::RES_W-1:0]  c_quadrature,
    output logic                              no_modulation
);
    localparam int MW = 3 * lia_pkg::SMP_W;

    logic [lia_pkg::CFG_W-1:0]          lo_reg;
    logic [lia_pkg::CFG_W-1:0]          hi_reg;
    logic [lia_pkg::CFG_W-1:0]          gain_reg;

    logic [lia_pkg::IDX_W-1:0]          idx_reg;
    logic [lia_pkg::LVL_W-1:0]          prev_reg;
    logic [lia_pkg::ADDR_W-1:0]         fall_reg;
    logic [lia_pkg::ADDR_W-1:0]         off_reg;
    logic                               seen_reg;
    logic [lia_pkg::PS_W-1:0]           ps_reg;
    logic [lia_pkg::EC_W-1:0]           ec_reg;

    logic [MW-1:0]                      mem [0:lia_pkg::SAMPLES-1];
    logic [MW-1:0]                      rd_reg;

    logic [lia_pkg::IDX_W-1:0]          s_reg;
    logic [lia_pkg::PS_W-1:0]           r_reg;
    logic [lia_pkg::DEPTH_W-1:0]        k_reg;
    logic [lia_pkg::PS_W-1:0]           f_reg;
    logic [lia_pkg::Q_W-1:0]            q_reg;
    logic [lia_pkg::PS_W-1:0]           e_reg;
    logic [2:0]                         mac_reg;
    logic signed [lia_pkg::ACC_W-1:0]   acc_reg [0:5];
    logic signed [lia_pkg::RES_W-1:0]   res_reg [0:5];
    logic                               nomod_reg;

    logic [lia_pkg::IDX_W-1:0]          p;
    logic                               fall;
    logic                               rise;
    logic [lia_pkg::DVD_W-1:0]          dividend;
    logic [lia_pkg::PS_W-1:0]           divisor;
    logic [lia_pkg::DVD_W-1:0]          quot;
    logic [lia_pkg::PS_W-1:0]           rem;
    logic                               div_done;
    logic [lia_pkg::PS_W-1:0]           r0;
    logic [lia_pkg::ADDR_W+lia_pkg::EC_W-1:0] off_ec;
    logic [lia_pkg::CFG_W-1:0]          gain_eff;
    logic signed [lia_pkg::ACC_W-1:0]   acc_sel;
    logic [lia_pkg::ACC_W-1:0]          mag;
    logic [lia_pkg::RES_W-1:0]          qres;
    logic signed [lia_pkg::SMP_W-1:0]   sn;
    logic signed [lia_pkg::SMP_W-1:0]   cs;
    logic                               cor_done;
    logic signed [lia_pkg::SMP_W-1:0]   smp;
    logic signed [2*lia_pkg::SMP_W-1:0] prod;
    logic [lia_pkg::PS_W:0]             rs;
    logic [lia_pkg::PS_W:0]             fs;
    logic                               r_wrap;
    logic                               f_wrap;
    logic [lia_pkg::DEPTH_W+1:0]        k1;
    logic [lia_pkg::DEPTH_W+1:0]        k2;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= lia_pkg::LOW_RST;
            hi_reg   <= lia_pkg::HIGH_RST;
            gain_reg <= lia_pkg::GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lia_pkg::CFG_LOW:  lo_reg   <= cfg_data;
                lia_pkg::CFG_HIGH: hi_reg   <= cfg_data;
                lia_pkg::CFG_GAIN: gain_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // edge detection while loading
    always_comb
    begin
        p    = idx_reg - 1'b1;
        fall = (idx_reg != '0) && (prev_reg > hi_reg) && (ref_level < lo_reg);
        rise = (idx_reg != '0) && !fall && (prev_reg < lo_reg) &&
               (ref_level > hi_reg) && (p[lia_pkg::ADDR_W-1:0] > off_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            prev_reg <= '0;
            fall_reg <= '0;
            off_reg  <= '0;
            seen_reg <= 1'b0;
            ps_reg   <= '0;
            ec_reg   <= '0;
        end
        else if (cmd.clr)
        begin
            idx_reg  <= '0;
            prev_reg <= '0;
            fall_reg <= '0;
            off_reg  <= '0;
            seen_reg <= 1'b0;
            ps_reg   <= '0;
            ec_reg   <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg  <= idx_reg + 1'b1;
            prev_reg <= ref_level;
            if (fall)
            begin
                fall_reg <= p[lia_pkg::ADDR_W-1:0];
                if (!seen_reg)
                begin
                    off_reg  <= p[lia_pkg::ADDR_W-1:0];
                    seen_reg <= 1'b1;
                end
            end
            else if (rise)
            begin
                ps_reg <= ps_reg + lia_pkg::PS_W'({p[lia_pkg::ADDR_W-1:0] - fall_reg, 1'b0});
                ec_reg <= ec_reg + 1'b1;
            end
        end
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[idx_reg[lia_pkg::ADDR_W-1:0]] <= {chan_c, chan_b, chan_a};
        if (cmd.rd)
            rd_reg <= mem[s_reg[lia_pkg::ADDR_W-1:0]];
    end

    // shared divider operands
    always_comb
    begin
        gain_eff = (gain_reg == '0) ? lia_pkg::CFG_W'(1) : gain_reg;
        r0       = (rem == '0) ? '0 : ps_reg - rem;
        off_ec   = off_reg * ec_reg;
        acc_sel  = acc_reg[mac_reg];
        mag      = acc_sel[lia_pkg::ACC_W-1] ? lia_pkg::ACC_W'(-acc_sel)
                                              : lia_pkg::ACC_W'(acc_sel);
        qres     = acc_sel[lia_pkg::ACC_W-1] ? -quot[lia_pkg::RES_W-1:0]
                                              : quot[lia_pkg::RES_W-1:0];
        divisor  = ps_reg;
        case (cmd.dsel)
            lia_pkg::DSEL_OFF: dividend = lia_pkg::DVD_W'(off_ec);
            lia_pkg::DSEL_PH:  dividend = lia_pkg::DVD_W'({r0, {lia_pkg::DEPTH_W{1'b0}}});
            lia_pkg::DSEL_ST:  dividend = lia_pkg::DVD_W'({ec_reg, {lia_pkg::DEPTH_W{1'b0}}});
            lia_pkg::DSEL_OUT:
            begin
                dividend = mag >> lia_pkg::SHIFT_N;
                divisor  = lia_pkg::PS_W'(gain_eff);
            end
            default:           dividend = '0;
        endcase
    end

    lia_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quot     (quot),
        .rem      (rem),
        .done     (div_done)
    );

    lia_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cor_start),
        .k     (k_reg),
        .sn    (sn),
        .cs    (cs),
        .done  (cor_done)
    );

    // MAC operand and phase stepping
    always_comb
    begin
        case (mac_reg[2:1])
            2'd0:    smp = rd_reg[lia_pkg::SMP_W-1:0];
            2'd1:    smp = rd_reg[2*lia_pkg::SMP_W-1:lia_pkg::SMP_W];
            default: smp = rd_reg[MW-1:2*lia_pkg::SMP_W];
        endcase
        prod   = smp * (mac_reg[0] ? cs : sn);
        rs     = {1'b0, r_reg} + (lia_pkg::PS_W+1)'(ec_reg);
        fs     = {1'b0, f_reg} + {1'b0, e_reg};
        r_wrap = (rs >= {1'b0, ps_reg});
        f_wrap = (fs >= {1'b0, ps_reg});
        k1     = {2'b00, k_reg} + (lia_pkg::DEPTH_W+2)'(q_reg) +
                 (lia_pkg::DEPTH_W+2)'(f_wrap);
        k2     = r_wrap ? k1 - (lia_pkg::DEPTH_W+2)'(1 << lia_pkg::DEPTH_W) : k1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            s_reg     <= '0;
            nomod_reg <= sts.no_edge;
            for (int j = 0; j < 6; j++)
            begin
                acc_reg[j] <= '0;
                res_reg[j] <= '0;
            end
        end
        if (cmd.div_take)
        begin
            case (cmd.dsel)
                lia_pkg::DSEL_OFF: r_reg <= r0;
                lia_pkg::DSEL_PH:
                begin
                    k_reg <= quot[lia_pkg::DEPTH_W-1:0];
                    f_reg <= rem;
                end
                lia_pkg::DSEL_ST:
                begin
                    q_reg <= quot[lia_pkg::Q_W-1:0];
                    e_reg <= rem;
                end
                lia_pkg::DSEL_OUT: res_reg[mac_reg] <= qres;
                default:           ;
            endcase
        end
        if (cmd.mac)
            acc_reg[mac_reg] <= acc_reg[mac_reg] + lia_pkg::ACC_W'(prod);
        if (cmd.adv)
        begin
            s_reg <= s_reg + 1'b1;
            r_reg <= r_wrap ? rs[lia_pkg::PS_W-1:0] - ps_reg : rs[lia_pkg::PS_W-1:0];
            f_reg <= f_wrap ? fs[lia_pkg::PS_W-1:0] - ps_reg : fs[lia_pkg::PS_W-1:0];
            k_reg <= k2[lia_pkg::DEPTH_W-1:0];
        end
    end

    // one index steps the MAC lanes and then the output scaling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_reg <= '0;
        else if (cmd.prep || cmd.adv)
            mac_reg <= '0;
        else if (cmd.mac || cmd.out_next)
            mac_reg <= mac_reg + 1'b1;
    end

    always_comb
    begin
        sts.closing   = frame_end ||
                        (idx_reg == lia_pkg::IDX_W'(lia_pkg::SAMPLES - 1));
        sts.no_edge   = (ec_reg == '0) || (ps_reg == '0);
        sts.div_done  = div_done;
        sts.cor_done  = cor_done;
        sts.mac_last  = (mac_reg == 3'd5);
        sts.samp_last = (s_reg == idx_reg - 1'b1);
        sts.out_last  = (mac_reg == 3'd5);
    end

    assign a_in_phase    = res_reg[0];
    assign a_quadrature  = res_reg[1];
    assign b_in_phase    = res_reg[2];
    assign b_quadrature  = res_reg[3];
    assign c_in_phase    = res_reg[4];
    assign c_quadrature  = res_reg[5];
    assign no_modulation = nomod_reg;

endmodule

/* hw/rtl/lia_ctrl.sv */
// ----------------------------------------------------------------------------
// lia_ctrl
// Sequencer: frame load, setup divisions, per-sample pass and scaling.
// ----------------------------------------------------------------------------
module lia_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lia_pkg::sts_t  sts,
    output lia_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);
    lia_pkg::state_t state_reg;
    lia_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lia_pkg::ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.dsel   = lia_pkg::DSEL_OFF;
        case (state_reg)
            lia_pkg::ST_LOAD:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.closing)
                        state_next = lia_pkg::ST_PREP;
                end
            end
            lia_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (sts.no_edge)
                    state_next = lia_pkg::ST_EMIT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = lia_pkg::ST_DIV_OFF;
                end
            end
            lia_pkg::ST_DIV_OFF:
            begin
                if (sts.div_done)
                begin
                    // take the offset phase
                    cmd.div_take = 1'b1;
                    state_next   = lia_pkg::ST_PH_GO;
                end
            end
            lia_pkg::ST_PH_GO:
            begin
                cmd.dsel      = lia_pkg::DSEL_PH;
                cmd.div_start = 1'b1;
                state_next    = lia_pkg::ST_DIV_PH;
            end
            lia_pkg::ST_DIV_PH:
            begin
                cmd.dsel = lia_pkg::DSEL_PH;
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = lia_pkg::ST_ST_GO;
                end
            end
            lia_pkg::ST_ST_GO:
            begin
                cmd.dsel      = lia_pkg::DSEL_ST;
                cmd.div_start = 1'b1;
                state_next    = lia_pkg::ST_DIV_ST;
            end
            lia_pkg::ST_DIV_ST:
            begin
                cmd.dsel = lia_pkg::DSEL_ST;
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = lia_pkg::ST_RD;
                end
            end
            lia_pkg::ST_RD:
            begin
                cmd.rd        = 1'b1;
                cmd.cor_start = 1'b1;
                state_next    = lia_pkg::ST_COR;
            end
            lia_pkg::ST_COR:
            begin
                if (sts.cor_done)
                    state_next = lia_pkg::ST_MAC;
            end
            lia_pkg::ST_MAC:
            begin
                cmd.mac = 1'b1;
                if (sts.mac_last)
                    state_next = lia_pkg::ST_ADV;
            end
            lia_pkg::ST_ADV:
            begin
                cmd.adv = 1'b1;
                if (sts.samp_last)
                    state_next = lia_pkg::ST_OUT_GO;
                else
                    state_next = lia_pkg::ST_RD;
            end
            lia_pkg::ST_OUT_GO:
            begin
                cmd.dsel      = lia_pkg::DSEL_OUT;
                cmd.div_start = 1'b1;
                state_next    = lia_pkg::ST_DIV_OUT;
            end
            lia_pkg::ST_DIV_OUT:
            begin
                cmd.dsel = lia_pkg::DSEL_OUT;
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    if (sts.out_last)
                        state_next = lia_pkg::ST_EMIT;
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = lia_pkg::ST_OUT_GO;
                    end
                end
            end
            lia_pkg::ST_EMIT:
            begin
                cmd.clr    = 1'b1;
                state_next = lia_pkg::ST_LOAD;
            end
            default:
                state_next = lia_pkg::ST_LOAD;
        endcase
    end

    assign busy = (state_reg != lia_pkg::ST_LOAD);
    assign done = (state_reg == lia_pkg::ST_EMIT);

endmodule

/* hw/rtl/lock_in_amplifier_three_channel.sv */
// ----------------------------------------------------------------------------
// lock_in_amplifier_three_channel
// Three-channel digital lock-in amplifier, one result per frame.
// ----------------------------------------------------------------------------
// Items transfer on start while busy is low: one per cycle while a frame loads.
// A frame closes on frame_end or on its 8192nd item; busy then rises for the
// evaluation pass and no item is taken until the result has gone out.
// Evaluation: three setup divisions, then for each stored sample a store
// read, a 24-step CORDIC, rounding, a MAC into each of the six lanes through
// one multiplier and a phase advance, then six divisions by the gain. With
// no counted rising edge the sequencer goes from the closing item through
// PREP straight to EMIT.
// The result is marked by done, which is high for a single cycle; the
// receiver cannot stall it. Configuration writes take effect at
// once and are meant for idle periods between frames.
// After reset the thresholds and gain hold their defaults and a new frame
// starts empty; the sample store is not cleared, every entry read is first
// written by the frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lock_in_amplifier_three_channel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [lia_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [lia_pkg::LVL_W-1:0]         ref_level,
    input  logic signed [lia_pkg::SMP_W-1:0]  chan_a,
    input  logic signed [lia_pkg::SMP_W-1:0]  chan_b,
    input  logic signed [lia_pkg::SMP_W-1:0]  chan_c,
    input  logic                              frame_end,
    output logic                              done,
    output logic signed [lia_pkg::RES_W-1:0]  a_in_phase,
    output logic signed [lia_pkg::RES_W-1:0]  a_quadrature,
    output logic signed [lia_pkg::RES_W-1:0]  b_in_phase,
    output logic signed [lia_pkg::RES_W-1:0]  b_quadrature,
    output logic signed [lia_pkg::RES_W-1:0]  c_in_phase,
    output logic signed [lia_pkg::RES_W-1:0]  c_quadrature,
    output logic                              no_modulation
);
    lia_pkg::cmd_t cmd;
    lia_pkg::sts_t sts;

    lia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lia_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ref_level     (ref_level),
        .chan_a        (chan_a),
        .chan_b        (chan_b),
        .chan_c        (chan_c),
        .frame_end     (frame_end),
        .cmd           (cmd),
        .sts           (sts),
        .a_in_phase    (a_in_phase),
        .a_quadrature  (a_quadrature),
        .b_in_phase    (b_in_phase),
        .b_quadrature  (b_quadrature),
        .c_in_phase    (c_in_phase),
        .c_quadrature  (c_quadrature),
        .no_modulation (no_modulation)
    );

    `ASSERT_NEXT(a_close_busy, clk, rst_n, start && !busy && sts.closing, busy)
    `ASSERT_SAME(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_NEXT(a_done_free, clk, rst_n, done, !busy && !done)
    `ASSERT_SAME(a_load_idle, clk, rst_n, cmd.load, !busy)

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Frame-level check of the three-channel lock-in amplifier: square-wave and
// noisy reference frames with random channel samples, over several threshold
// and gain settings, are predicted in fixed point and compared per frame.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int HOLD_OFF    = 20;
    localparam int CYCLE_LIMIT = 3000000;

    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_kind_t;

    typedef struct {
        act_kind_t          kind;
        logic [15:0]        lvl;
        logic signed [15:0] sa;
        logic signed [15:0] sb;
        logic signed [15:0] sc;
        logic               fe;
        int                 gap;
        logic [1:0]         idx;
    } action_t;

    typedef struct {
        logic signed [31:0] val [6];
        logic               nm;
    } readout_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = 2'd0;
    logic [15:0]        cfg_data = 16'd0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        ref_level = 16'd0;
    logic signed [15:0] chan_a = 16'sd0;
    logic signed [15:0] chan_b = 16'sd0;
    logic signed [15:0] chan_c = 16'sd0;
    logic               frame_end = 1'b0;
    logic               done;
    logic signed [31:0] a_in_phase, a_quadrature, b_in_phase, b_quadrature;
    logic signed [31:0] c_in_phase, c_quadrature;
    logic               no_modulation;

    lock_in_amplifier_three_channel u_top (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .ref_level(ref_level),
        .chan_a(chan_a), .chan_b(chan_b), .chan_c(chan_c), .frame_end(frame_end),
        .done(done), .a_in_phase(a_in_phase), .a_quadrature(a_quadrature),
        .b_in_phase(b_in_phase), .b_quadrature(b_quadrature),
        .c_in_phase(c_in_phase), .c_quadrature(c_quadrature),
        .no_modulation(no_modulation)
    );

    always #5 clk = ~clk;

    action_t  pending_actions[$];
    readout_t pending_readouts[$];
    int       mismatches = 0;
    int       hold_cnt = 0;
    int       cycles = 0;

    // generator's view of the thresholds
    int gen_lo = 6554;
    int gen_hi = 58982;

    // predictor state
    logic [15:0]        lk_lo = lia_pkg::LOW_RST;
    logic [15:0]        lk_hi = lia_pkg::HIGH_RST;
    logic [15:0]        lk_gain = lia_pkg::GAIN_RST;
    logic signed [15:0] lk_store [lia_pkg::SAMPLES][3];
    int unsigned        lk_index, lk_prev, lk_last_fall, lk_offset, lk_edges;
    bit                 lk_fall_seen;
    longint unsigned    lk_psum;

    const longint turn_step [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
        333772, 166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    function automatic int round_q15(input longint v);
        longint t;
        t = (v + 16384) >>> 15;
        if (t > 32767)
            t = 32767;
        if (t < -32767)
            t = -32767;
        return int'(t);
    endfunction

    function automatic void rotate_ref(input logic [31:0] ang, output int sn, output int cs);
        longint      x, y, z, dx, dy;
        logic [31:0] a2;
        bit          flip;
        x = 652032874;
        y = 0;
        a2 = ang;
        flip = 1'b0;
        if (ang >= 32'h4000_0000 && ang < 32'hC000_0000)
        begin
            a2 = ang - 32'h8000_0000;
            flip = 1'b1;
        end
        z = (a2 < 32'h8000_0000) ? longint'(a2) : longint'(a2) - 64'sd4294967296;
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= turn_step[i];
            end
            else
            begin
                x += dx; y -= dy; z += turn_step[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        sn = round_q15(y);
        cs = round_q15(x);
    endfunction

    function automatic void clear_lock_in();
        lk_index = 0; lk_prev = 0; lk_last_fall = 0; lk_offset = 0;
        lk_fall_seen = 1'b0; lk_psum = 0; lk_edges = 0;
    endfunction

    // take one accepted sample; returns 1 when the frame closes
    function automatic bit lock_in_take(input action_t it, output readout_t res);
        int unsigned s, p;
        longint      acc [6];
        longint      n, r, ps, dv;
        longint      k;
        int          sn, cs;
        s = lk_index;
        lk_store[s][0] = it.sa;
        lk_store[s][1] = it.sb;
        lk_store[s][2] = it.sc;
        if (s > 0)
        begin
            p = s - 1;
            if (lk_prev > lk_hi && it.lvl < lk_lo)
            begin
                lk_last_fall = p;
                if (!lk_fall_seen)
                begin
                    lk_offset = p;
                    lk_fall_seen = 1'b1;
                end
            end
            else if (lk_prev < lk_lo && it.lvl > lk_hi && p > lk_offset)
            begin
                lk_psum += 2 * (p - lk_last_fall);
                lk_edges++;
            end
        end
        lk_prev = it.lvl;
        lk_index = s + 1;
        if (!it.fe && lk_index < lia_pkg::SAMPLES)
            return 1'b0;
        foreach (res.val[j])
            res.val[j] = '0;
        res.nm = 1'b0;
        if (lk_edges == 0 || lk_psum == 0)
            res.nm = 1'b1;
        else
        begin
            foreach (acc[j])
                acc[j] = 0;
            ps = longint'(lk_psum);
            for (int unsigned q = 0; q < lk_index; q++)
            begin
                n = (longint'(q) - longint'(lk_offset)) * longint'(lk_edges);
                r = n % ps;
                if (r < 0)
                    r += ps;
                k = (r * 1024) / ps;
                rotate_ref(32'(k << 22), sn, cs);
                for (int c = 0; c < 3; c++)
                begin
                    acc[2*c]   += longint'(lk_store[q][c]) * sn;
                    acc[2*c+1] += longint'(lk_store[q][c]) * cs;
                end
            end
            dv = longint'(lia_pkg::SAMPLES) * ((lk_gain != 0) ? longint'(lk_gain) : 1);
            foreach (acc[j])
                res.val[j] = 32'(acc[j] / dv);
        end
        clear_lock_in();
        return 1'b1;
    endfunction

    // ---------------- stimulus construction ----------------

    function automatic void push_sample(int lvl, int sa, int sb, int sc, bit fe, int gap);
        action_t it;
        it.kind = ACT_ITEM; it.lvl = 16'(lvl); it.sa = 16'(sa); it.sb = 16'(sb);
        it.sc = 16'(sc); it.fe = fe; it.gap = gap; it.idx = '0;
        pending_actions.push_back(it);
    endfunction

    function automatic void push_reg(logic [1:0] idx, int val);
        action_t it;
        it.kind = ACT_CFG; it.idx = idx; it.lvl = 16'(val);
        it.sa = '0; it.sb = '0; it.sc = '0; it.fe = 1'b0; it.gap = 0;
        pending_actions.push_back(it);
        if (idx == lia_pkg::CFG_LOW)
            gen_lo = val;
        else if (idx == lia_pkg::CFG_HIGH)
            gen_hi = val;
    endfunction

    function automatic void push_drain();
        action_t it;
        it.kind = ACT_DRAIN; it.lvl = '0; it.sa = '0; it.sb = '0; it.sc = '0;
        it.fe = 1'b0; it.gap = 0; it.idx = '0;
        pending_actions.push_back(it);
    endfunction

    function automatic int high_level();
        return (gen_hi >= 65535) ? 65535 : int'($urandom_range(65535, gen_hi + 1));
    endfunction

    function automatic int low_level();
        return (gen_lo <= 0) ? 0 : int'($urandom_range(gen_lo - 1, 0));
    endfunction

    // style: 0 square wave, 1 noise, 2 constant; fe_on_last=0 lets the store fill
    function automatic int build_frame(int len, int style, bit quick, bit fe_on_last);
        int half, ph, lvl, gap, cval;
        half = $urandom_range(6, 1);
        ph = $urandom_range(2 * half - 1, 0);
        cval = $urandom_range(65535, 0);
        for (int i = 0; i < len; i++)
        begin
            if (style == 1)
                lvl = $urandom_range(65535, 0);
            else if (style == 2)
                lvl = cval;
            else if ($urandom_range(19, 0) == 0)
                lvl = $urandom_range(65535, 0);
            else
                lvl = (((i + ph) / half) % 2 == 0) ? high_level() : low_level();
            gap = quick ? 0 : int'($urandom_range(12, 0));
            push_sample(lvl, $urandom, $urandom, $urandom,
                        fe_on_last && (i == len - 1), gap);
        end
        return len;
    endfunction

    function automatic void build_stimulus();
        int issued, st, ln;
        // directed: extremes, edges, single-item frame, flat frame
        push_sample(65535, 32767, -32768, 0, 1'b0, 0);
        push_sample(0, -32768, 32767, -1, 1'b0, 1);
        push_sample(65535, 0, -1, 32767, 1'b0, 0);
        push_sample(0, -1, 0, -32768, 1'b0, 3);
        push_sample(65535, 32767, 32767, 32767, 1'b0, 0);
        push_sample(0, -32768, -32768, -32768, 1'b0, 0);
        push_sample(65535, 12345, -12345, 1, 1'b1, 2);
        push_sample(65535, 32767, 32767, 32767, 1'b1, 0);
        for (int i = 0; i < 4; i++)
            push_sample(0, -32768, 32767, 0, i == 3, 0);
        // threshold and gain phases, extremes among them
        for (int phase = 0; phase < 6; phase++)
        begin
            push_drain();
            case (phase)
                0: begin push_reg(lia_pkg::CFG_GAIN, 0); end
                1: begin push_reg(lia_pkg::CFG_LOW, 0); push_reg(lia_pkg::CFG_HIGH, 65535);
                         push_reg(lia_pkg::CFG_GAIN, 65535); end
                2: begin push_reg(lia_pkg::CFG_LOW, 65535); push_reg(lia_pkg::CFG_HIGH, 0);
                         push_reg(lia_pkg::CFG_GAIN, 1); end
                3: begin push_reg(lia_pkg::CFG_LOW, $urandom_range(40000, 1000));
                         push_reg(lia_pkg::CFG_HIGH, $urandom_range(65000, 40001));
                         push_reg(lia_pkg::CFG_GAIN, $urandom_range(300, 2)); end
                4: begin push_reg(CFG_SPARE, $urandom); push_reg(lia_pkg::CFG_LOW, 6554);
                         push_reg(lia_pkg::CFG_HIGH, 58982);
                         push_reg(lia_pkg::CFG_GAIN, 3); end
                default: begin push_reg(lia_pkg::CFG_GAIN, $urandom_range(65535, 1)); end
            endcase
            issued = 0;
            while (issued < 220)
            begin
                st = $urandom_range(9, 0);
                st = (st < 7) ? 0 : (st < 9) ? 1 : 2;
                ln = ($urandom_range(9, 0) == 0) ? int'($urandom_range(64, 20))
                                                 : int'($urandom_range(18, 1));
                issued += build_frame(ln, st, $urandom_range(3, 0) == 0, 1'b1);
            end
        end
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        action_t  head;
        readout_t res;
        logic     start_n, wr_n;
        logic [1:0]  idx_n;
        logic [15:0] data_n;
        start_n = start;
        wr_n = 1'b0;
        idx_n = cfg_index;
        data_n = cfg_data;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                head = pending_actions.pop_front();
                if (lock_in_take(head, res))
                    pending_readouts.push_back(res);
                start_n = 1'b0;
            end
            if (!(start && busy))
            begin
                if (hold_cnt > 0)
                    hold_cnt--;
                else if (pending_actions.size() > 0)
                begin
                    head = pending_actions[0];
                    case (head.kind)
                        ACT_ITEM:
                        begin
                            if (head.gap > 0)
                                pending_actions[0].gap = head.gap - 1;
                            else
                            begin
                                start_n = 1'b1;
                                ref_level <= head.lvl;
                                chan_a <= head.sa;
                                chan_b <= head.sb;
                                chan_c <= head.sc;
                                frame_end <= head.fe;
                            end
                        end
                        ACT_CFG:
                        begin
                            void'(pending_actions.pop_front());
                            wr_n = 1'b1;
                            idx_n = head.idx;
                            data_n = head.lvl;
                            if (head.idx == lia_pkg::CFG_LOW)
                                lk_lo = head.lvl;
                            else if (head.idx == lia_pkg::CFG_HIGH)
                                lk_hi = head.lvl;
                            else if (head.idx == lia_pkg::CFG_GAIN)
                                lk_gain = head.lvl;
                        end
                        default:
                        begin
                            // hold until every frame result is back, then settle
                            if (pending_readouts.size() == 0 && !busy)
                            begin
                                void'(pending_actions.pop_front());
                                hold_cnt = HOLD_OFF;
                            end
                        end
                    endcase
                end
            end
        end
        start <= start_n;
        cfg_write <= wr_n;
        cfg_index <= idx_n;
        cfg_data <= data_n;
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        readout_t want;
        logic signed [31:0] got [6];
        if (rst_n && done)
        begin
            got = '{a_in_phase, a_quadrature, b_in_phase, b_quadrature,
                    c_in_phase, c_quadrature};
            if (pending_readouts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at cycle %0d", cycles);
            end
            else
            begin
                want = pending_readouts.pop_front();
                for (int j = 0; j < 6; j++)
                begin
                    if (got[j] !== want.val[j])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("value %0d: expected %0d, got %0d", j,
                                     want.val[j], got[j]);
                    end
                end
                if (no_modulation !== want.nm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("no_modulation: expected %0b, got %0b",
                                 want.nm, no_modulation);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clear_lock_in();
        build_stimulus();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pending_actions.size() == 0 && !start && pending_readouts.size() == 0)
                break;
        end
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_readouts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
